FILE: rtl/tsd_pkg.sv
// Shared types, constants and helpers for the tar stream deframer.
// No dependencies; every other file of the block but tsd_in_if imports this package.
`default_nettype none
package tsd_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned SIZE_W      = 36;
  localparam int unsigned MODE_W      = 24;

  localparam logic [POS_W-1:0] BLOCK_LAST = POS_W'(BLOCK_BYTES - 1);
  localparam logic [POS_W-1:0] MODE_FIRST = POS_W'(100);
  localparam logic [POS_W-1:0] MODE_LAST  = POS_W'(107);
  localparam logic [POS_W-1:0] SIZE_FIRST = POS_W'(124);
  localparam logic [POS_W-1:0] SIZE_LAST  = POS_W'(135);
  localparam logic [POS_W-1:0] TYPE_POS   = POS_W'(156);
  localparam logic [POS_W-1:0] PREFIX_POS = POS_W'(345);

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CH_SYM   = 8'h32;  // '2'
  localparam logic [7:0] CH_DIR   = 8'h35;  // '5'

  localparam logic [2:0] CLASS_HEADER = 3'd0;
  localparam logic [2:0] CLASS_FILE   = 3'd1;
  localparam logic [2:0] CLASS_SKIP   = 3'd2;
  localparam logic [2:0] CLASS_PAD    = 3'd3;
  localparam logic [2:0] CLASS_DONE   = 3'd4;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_DIR   = 2'd1;
  localparam logic [1:0] KIND_SYM   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [2:0]        byte_class;
    logic              header_end;
    logic              end_of_archive;
    logic [1:0]        entry_kind;
    logic [SIZE_W-1:0] entry_size;
    logic [MODE_W-1:0] entry_mode;
    logic              has_prefix;
  } tsd_result_t;

  function automatic logic [1:0] kind_of(input logic [7:0] t);
    logic [1:0] k;
    if (t == CH_ZERO || t == 8'h00) k = KIND_REG;
    else if (t == CH_DIR)           k = KIND_DIR;
    else if (t == CH_SYM)           k = KIND_SYM;
    else                            k = KIND_OTHER;
    return k;
  endfunction

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tsd_in_if.sv
// Input byte channel: valid/ready handshake carrying one tar stream byte.
// Depends on nothing.
`default_nettype none
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsd_out_if.sv
// Result channel: valid/ready handshake carrying a classified byte.
// Depends on tsd_pkg for field widths.
`default_nettype none
interface tsd_out_if import tsd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic [2:0]        byte_class;
  logic              header_end;
  logic              end_of_archive;
  logic [1:0]        entry_kind;
  logic [SIZE_W-1:0] entry_size;
  logic [MODE_W-1:0] entry_mode;
  logic              has_prefix;

  modport source (output valid, output out_byte, output byte_class, output header_end,
                  output end_of_archive, output entry_kind, output entry_size,
                  output entry_mode, output has_prefix, input ready);
  modport sink   (input valid, input out_byte, input byte_class, input header_end,
                  input end_of_archive, input entry_kind, input entry_size,
                  input entry_mode, input has_prefix, output ready);
endinterface
`default_nettype wire

FILE: rtl/tar_stream_deframer.sv
// Tar stream deframer top level: byte input channel, classified byte output.
// Depends on tsd_pkg, tsd_in_if, tsd_out_if, tsd_parse and tsd_out_reg.
//
// Usage:
//   in_ch carries one byte of an uncompressed tar archive per transaction.
//   out_ch returns exactly one result per input byte, in order: the byte, its
//   class (header, file payload, skipped payload, padding, after end), and at
//   the last byte of each 512-byte header the parsed kind, size, mode and
//   prefix flag, with end_of_archive set for an all-zero header.
//   A result is offered on out_ch in the cycle after its byte is taken.
//   Throughput: one byte per cycle while out_ch takes results; the combinational
//   parse of each byte and one result register set the rate.
//   in_ch.ready is high whenever the result register is empty or its result is
//   taken in the same cycle, so a stalled receiver holds at most one result
//   and back-pressures the input.
//   Reset (rst_n low, synchronous) returns to the start of a header block and
//   empties the result register. After an end-of-archive header every byte is
//   reported as after-end until the next reset.
`default_nettype none
module tar_stream_deframer import tsd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tsd_in_if.sink     in_ch,
  tsd_out_if.source  out_ch
);

  tsd_result_t res;
  logic        slot_free;
  logic        fire;

  assign in_ch.ready = slot_free;
  assign fire        = in_ch.valid && slot_free;

  tsd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_ch.data_byte),
    .res       (res)
  );

  tsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  a_eoa_at_header_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_archive |->
      out_ch.header_end && out_ch.byte_class == CLASS_HEADER)
    else $error("end_of_archive outside a header end");

  a_fields_only_at_header_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.header_end |->
      out_ch.entry_size == '0 && out_ch.entry_mode == '0 && !out_ch.has_prefix)
    else $error("entry fields set away from header end");

  a_accept_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> out_ch.valid)
    else $error("accepted byte produced no result");

  a_after_end_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.end_of_archive ##1
      (in_ch.valid && in_ch.ready) |=> out_ch.byte_class == CLASS_DONE)
    else $error("byte after archive end not classed as after-end");

endmodule
`default_nettype wire

FILE: rtl/tsd_parse.sv
// Block tracking and header field parsing for the tar stream deframer.
// Depends on tsd_pkg; computes the result for the offered byte combinationally.
`default_nettype none
module tsd_parse import tsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic [7:0]  data_byte,
  output tsd_result_t      res
);

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_PAD, PH_DONE} phase_t;

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SIZE_W-1:0] remain_r, remain_nxt;
  logic [SIZE_W-1:0] size_acc_r, size_acc_nxt;
  logic [MODE_W-1:0] mode_acc_r, mode_acc_nxt;
  logic              size_stop_r, size_stop_nxt;
  logic              mode_stop_r, mode_stop_nxt;
  logic [7:0]        type_r, type_nxt;
  logic              nonzero_r, nonzero_nxt;
  logic              prefix_r, prefix_nxt;

  logic [POS_W-1:0]  pos_inc;
  logic [SIZE_W-1:0] remain_dec;
  logic              byte_nz;

  assign pos_inc = pos_r + POS_W'(1);
  assign byte_nz = (data_byte != 8'h00);
  assign remain_dec = (remain_r != '0) ? remain_r - SIZE_W'(1) : remain_r;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    remain_nxt    = remain_r;
    size_acc_nxt  = size_acc_r;
    mode_acc_nxt  = mode_acc_r;
    size_stop_nxt = size_stop_r;
    mode_stop_nxt = mode_stop_r;
    type_nxt      = type_r;
    nonzero_nxt   = nonzero_r;
    prefix_nxt    = prefix_r;
    res            = '0;
    res.out_byte   = data_byte;
    res.byte_class = CLASS_DONE;

    case (phase_r)
      PH_HEADER: begin
        res.byte_class = CLASS_HEADER;
        pos_nxt        = pos_inc;
        if (byte_nz) nonzero_nxt = 1'b1;
        if (pos_r >= MODE_FIRST && pos_r <= MODE_LAST && !mode_stop_r) begin
          if (!byte_nz) mode_stop_nxt = 1'b1;
          else if (is_octal(data_byte))
            mode_acc_nxt = {mode_acc_r[MODE_W-4:0], 3'b000} + MODE_W'(data_byte[2:0]);
        end
        if (pos_r >= SIZE_FIRST && pos_r <= SIZE_LAST && !size_stop_r) begin
          if (!byte_nz) size_stop_nxt = 1'b1;
          else if (is_octal(data_byte))
            size_acc_nxt = {size_acc_r[SIZE_W-4:0], 3'b000} + SIZE_W'(data_byte[2:0]);
        end
        if (pos_r == TYPE_POS) type_nxt = data_byte;
        if (pos_r == PREFIX_POS) prefix_nxt = byte_nz;
        if (pos_r == BLOCK_LAST) begin
          res.header_end = 1'b1;
          res.entry_kind = kind_of(type_r);
          res.entry_size = size_acc_r;
          res.entry_mode = mode_acc_r;
          res.has_prefix = prefix_r;
          if (!(nonzero_r || byte_nz)) begin
            res.end_of_archive = 1'b1;
            phase_nxt          = PH_DONE;
          end else begin
            remain_nxt = size_acc_r;
            phase_nxt  = (size_acc_r != '0) ? PH_PAYLOAD : PH_HEADER;
          end
          size_acc_nxt  = '0;
          mode_acc_nxt  = '0;
          size_stop_nxt = 1'b0;
          mode_stop_nxt = 1'b0;
          nonzero_nxt   = 1'b0;
          prefix_nxt    = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        res.byte_class = (kind_of(type_r) == KIND_REG) ? CLASS_FILE : CLASS_SKIP;
        remain_nxt     = remain_dec;
        pos_nxt        = pos_inc;
        if (remain_dec == '0) phase_nxt = (pos_inc == '0) ? PH_HEADER : PH_PAD;
      end
      PH_PAD: begin
        res.byte_class = CLASS_PAD;
        pos_nxt        = pos_inc;
        if (pos_inc == '0) phase_nxt = PH_HEADER;
      end
      default: begin
        res.byte_class = CLASS_DONE;
      end
    endcase
  end

  // advance only on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      remain_r    <= '0;
      size_acc_r  <= '0;
      mode_acc_r  <= '0;
      size_stop_r <= 1'b0;
      mode_stop_r <= 1'b0;
      type_r      <= '0;
      nonzero_r   <= 1'b0;
      prefix_r    <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      remain_r    <= remain_nxt;
      size_acc_r  <= size_acc_nxt;
      mode_acc_r  <= mode_acc_nxt;
      size_stop_r <= size_stop_nxt;
      mode_stop_r <= mode_stop_nxt;
      type_r      <= type_nxt;
      nonzero_r   <= nonzero_nxt;
      prefix_r    <= prefix_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tsd_out_reg.sv
// Result register of the tar stream deframer: holds one result until taken.
// Depends on tsd_pkg and tsd_out_if.
`default_nettype none
module tsd_out_reg import tsd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire tsd_result_t  res,
  output logic              slot_free,
  tsd_out_if.source         out_ch
);

  tsd_result_t res_r;
  logic        valid_r, valid_nxt;

  // free when empty or when the held result leaves this cycle
  assign slot_free = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.out_byte       = res_r.out_byte;
  assign out_ch.byte_class     = res_r.byte_class;
  assign out_ch.header_end     = res_r.header_end;
  assign out_ch.end_of_archive = res_r.end_of_archive;
  assign out_ch.entry_kind     = res_r.entry_kind;
  assign out_ch.entry_size     = res_r.entry_size;
  assign out_ch.entry_mode     = res_r.entry_mode;
  assign out_ch.has_prefix     = res_r.has_prefix;

endmodule
`default_nettype wire
